// ===== sv/eibg_pkg.sv =====
// ----------------------------------------------------------------------------
// eibg_pkg
// Shared types and constants of the equal interval break generator: sequencer
// states, configuration register indexes and class count widths.
// ----------------------------------------------------------------------------
package eibg_pkg;

    // width of the requested class count field
    localparam int COUNT_BITS = 6;
    // width of an internal class count, holds up to 64
    localparam int NUM_BITS = 7;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SYM_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SYM_ASTRIDE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SYM_POINT   = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ABS,
        ST_PICK,
        ST_LAUNCH,
        ST_DIV,
        ST_BACK,
        ST_EMIT
    } eibg_state_t;

endpackage

// ===== sv/eibg_div.sv =====
// ----------------------------------------------------------------------------
// eibg_div
// Serial restoring divider: unsigned dividend by an unsigned class count, one
// quotient bit per cycle, done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module eibg_div #(
    parameter int DIVIDEND_BITS = 33
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [DIVIDEND_BITS-1:0]          dividend,
    input  logic [eibg_pkg::NUM_BITS-1:0]     divisor,
    output logic                              done,
    output logic [DIVIDEND_BITS-1:0]          quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [CNT_BITS-1:0]              cnt_reg;
    logic [DIVIDEND_BITS-1:0]         quo_reg;
    logic [eibg_pkg::NUM_BITS-1:0]    rem_reg;
    logic [eibg_pkg::NUM_BITS:0]      trial;
    logic                             fits;

    // trial subtraction of the divisor from the shifted partial remainder
    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        fits  = (trial >= {1'b0, divisor});
    end

    // control: busy flag, bit counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIVIDEND_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            if (fits) begin
                rem_reg <= eibg_pkg::NUM_BITS'(trial - {1'b0, divisor});
            end else begin
                rem_reg <= trial[eibg_pkg::NUM_BITS-1:0];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/equal_interval_break_generator_core.sv =====
// ----------------------------------------------------------------------------
// equal_interval_break_generator_core
// Equal interval class break generator in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat on s_ carries range_min, range_max and class_count. The
//   block answers with one result beat on m_ per class: the upper break of the
//   class, its index, and tlast on the final break, which equals range_max.
//   The cfg_ channel writes the symmetric mode enable, the astride flag and the
//   symmetry point; cfg_ready is always high, writes belong between requests.
// Sequence:
//   After its beat a request passes the set-up states DIFF, ABS, PICK and LAUNCH,
//   then the serial divider, then steps back from the maximum in BACK when the
//   symmetric start lies below it, then emits one break per cycle while the
//   receiver keeps m_tready high, then returns to idle for the next request.
//   s_tready is high only while no request is in progress; the serial divider
//   and the one shared accumulator keep requests from overlapping.
// Reset and stalls:
//   Reset clears the sequencer, the configuration and m_tvalid, not the datapath.
//   A low m_tready holds the pending break in the output register and pauses the
//   sequencer; the last break may still wait there while the next request is taken.
// ----------------------------------------------------------------------------
module equal_interval_break_generator_core #(
    parameter int MAX_CLASSES = 63,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // request channel
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // tdata: range_min, range_max, class_count, zero padding
    input  logic [((2*VALUE_BITS+6+7)/8)*8-1:0]      s_tdata,
    // result channel
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // tdata: break_value, break_index, zero padding
    output logic [((VALUE_BITS+6+7)/8)*8-1:0]        m_tdata,
    // tlast: last_break
    output logic                                     m_tlast,
    // configuration write channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [eibg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [VALUE_BITS-1:0]                    cfg_data
);

    localparam int W         = VALUE_BITS + 4;
    localparam int DW        = VALUE_BITS + 2;
    localparam int NB        = eibg_pkg::NUM_BITS;
    localparam int CB        = eibg_pkg::COUNT_BITS;
    localparam int M_TDATA_W = ((VALUE_BITS + 6 + 7) / 8) * 8;

    localparam logic signed [W-1:0] VAL_MAX =
        {{(W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [W-1:0] VAL_MIN =
        {{(W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

    eibg_pkg::eibg_state_t state_reg, state_next;

    // configuration registers
    logic                        sym_en_reg;
    logic                        sym_astride_reg;
    logic [VALUE_BITS-1:0]       sym_point_reg;

    // request and working registers
    logic signed [W-1:0]         min_reg;
    logic signed [W-1:0]         max_reg;
    logic signed [W-1:0]         point_ext;
    logic [NB-1:0]               num_reg;
    logic signed [W-1:0]         d0_reg;
    logic signed [W-1:0]         d1_reg;
    logic                        neg_reg;
    logic                        low_start_reg;
    logic [DW-1:0]               dividend_reg;
    logic signed [W-1:0]         step_reg;
    logic signed [W-1:0]         run_reg;
    logic [NB-1:0]               cnt_reg;
    logic [NB-1:0]               last_idx_reg;

    // output register
    logic                        m_valid_reg;
    logic [VALUE_BITS-1:0]       m_value_reg;
    logic [CB-1:0]               m_index_reg;
    logic                        m_last_reg;

    // request fields and clamped count
    logic [VALUE_BITS-1:0]       in_min;
    logic [VALUE_BITS-1:0]       in_max;
    logic [CB-1:0]               in_count;
    logic [NB-1:0]               count_clamped;

    // divider hookup
    logic                        div_start;
    logic                        div_done;
    logic [DW-1:0]               div_quo;
    logic signed [W-1:0]         quo_ext;

    // accumulator and result selection
    logic                        emit_load;
    logic                        is_last;
    logic signed [W-1:0]         sum;
    logic [VALUE_BITS-1:0]       sat_value;
    logic                        below_lt;
    logic signed [W-1:0]         dmin;

    assign in_min   = s_tdata[VALUE_BITS-1:0];
    assign in_max   = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
    assign in_count = s_tdata[2*VALUE_BITS+CB-1:2*VALUE_BITS];

    assign point_ext = {{(W-VALUE_BITS){sym_point_reg[VALUE_BITS-1]}}, sym_point_reg};
    assign quo_ext   = {{(W-DW){1'b0}}, div_quo};

    // zero count means one class, large counts stop at the limit
    always_comb begin
        if (in_count == '0) begin
            count_clamped = NB'(1);
        end else if ({1'b0, in_count} > NB'(MAX_CLASSES)) begin
            count_clamped = NB'(MAX_CLASSES);
        end else begin
            count_clamped = {1'b0, in_count};
        end
    end

    // symmetric choice of the nearer side
    always_comb begin
        below_lt = (d0_reg < d1_reg);
        dmin     = below_lt ? d0_reg : d1_reg;
    end

    // next break and its saturation to the value range
    always_comb begin
        sum     = run_reg + step_reg;
        is_last = (cnt_reg == last_idx_reg);
        if (sum > VAL_MAX) begin
            sat_value = VAL_MAX[VALUE_BITS-1:0];
        end else if (sum < VAL_MIN) begin
            sat_value = VAL_MIN[VALUE_BITS-1:0];
        end else begin
            sat_value = sum[VALUE_BITS-1:0];
        end
    end

    // sequencer: next state and strobes
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        emit_load  = 1'b0;
        case (state_reg)
            eibg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = eibg_pkg::ST_DIFF;
                end
            end
            eibg_pkg::ST_DIFF:   state_next = eibg_pkg::ST_ABS;
            eibg_pkg::ST_ABS:    state_next = eibg_pkg::ST_PICK;
            eibg_pkg::ST_PICK:   state_next = eibg_pkg::ST_LAUNCH;
            eibg_pkg::ST_LAUNCH: begin
                div_start  = 1'b1;
                state_next = eibg_pkg::ST_DIV;
            end
            eibg_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = low_start_reg ? eibg_pkg::ST_EMIT : eibg_pkg::ST_BACK;
                end
            end
            eibg_pkg::ST_BACK: begin
                if (cnt_reg == '0) begin
                    state_next = eibg_pkg::ST_EMIT;
                end
            end
            eibg_pkg::ST_EMIT: begin
                emit_load = !m_valid_reg || m_tready;
                if (emit_load && is_last) begin
                    state_next = eibg_pkg::ST_IDLE;
                end
            end
            default: state_next = eibg_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eibg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_en_reg      <= 1'b0;
            sym_astride_reg <= 1'b0;
            sym_point_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                eibg_pkg::CFG_SYM_ENABLE:  sym_en_reg      <= cfg_data[0];
                eibg_pkg::CFG_SYM_ASTRIDE: sym_astride_reg <= cfg_data[0];
                eibg_pkg::CFG_SYM_POINT:   sym_point_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // working datapath, one step per state
    always_ff @(posedge aclk) begin
        case (state_reg)
            eibg_pkg::ST_IDLE: begin
                min_reg <= {{(W-VALUE_BITS){in_min[VALUE_BITS-1]}}, in_min};
                max_reg <= {{(W-VALUE_BITS){in_max[VALUE_BITS-1]}}, in_max};
                num_reg <= count_clamped;
            end
            eibg_pkg::ST_DIFF: begin
                d0_reg <= sym_en_reg ? (min_reg - point_ext) : (max_reg - min_reg);
                d1_reg <= max_reg - point_ext;
            end
            eibg_pkg::ST_ABS: begin
                neg_reg <= d0_reg[W-1];
                d0_reg  <= d0_reg[W-1] ? -d0_reg : d0_reg;
                d1_reg  <= d1_reg[W-1] ? -d1_reg : d1_reg;
            end
            eibg_pkg::ST_PICK: begin
                if (!sym_en_reg) begin
                    dividend_reg  <= d0_reg[DW-1:0];
                    low_start_reg <= 1'b1;
                end else begin
                    dividend_reg  <= {dmin[DW-2:0], 1'b0};
                    neg_reg       <= 1'b0;
                    low_start_reg <= below_lt;
                    // odd count when astride, even count otherwise
                    if (sym_astride_reg != num_reg[0]) begin
                        num_reg <= num_reg + NB'(1);
                    end
                end
            end
            eibg_pkg::ST_DIV: begin
                if (div_done) begin
                    step_reg     <= neg_reg ? -quo_ext : quo_ext;
                    run_reg      <= low_start_reg ? min_reg : max_reg;
                    cnt_reg      <= low_start_reg ? '0 : num_reg;
                    last_idx_reg <= num_reg - NB'(1);
                end
            end
            eibg_pkg::ST_BACK: begin
                // walk down from the maximum by n steps
                if (cnt_reg != '0) begin
                    run_reg <= run_reg - step_reg;
                    cnt_reg <= cnt_reg - NB'(1);
                end
            end
            eibg_pkg::ST_EMIT: begin
                if (emit_load) begin
                    run_reg <= sum;
                    cnt_reg <= cnt_reg + NB'(1);
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_value_reg <= is_last ? max_reg[VALUE_BITS-1:0] : sat_value;
            m_index_reg <= cnt_reg[CB-1:0];
            m_last_reg  <= is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_index_reg, m_value_reg});
    assign m_tlast  = m_last_reg;

    // shared serial divider
    eibg_div #(
        .DIVIDEND_BITS (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend_reg),
        .divisor  (num_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

endmodule
